/* rtl/dns_response_address_parser_assert.svh */
// Assertion macros used by the parser RTL.
`ifndef DNS_RESPONSE_ADDRESS_PARSER_ASSERT_SVH
`define DNS_RESPONSE_ADDRESS_PARSER_ASSERT_SVH

// Clocked assertion that is switched off while reset is asserted.
`define DRAP_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define DRAP_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/drap_pkg.sv */
package drap_pkg;

  // Default upper bound on the frame length in bytes.
  localparam int unsigned MaxFrameBytesDef = 2048;

  // Frames shorter than this never report a match.
  localparam int unsigned MinFrameBytes = 35;
  // Number of the byte after which the first type word starts.
  localparam int unsigned HdrBytes = 12;

  // Type words, first wire byte in the low half.
  localparam logic [15:0] TypeVlan   = 16'h0081;
  localparam logic [15:0] TypePppoe  = 16'h6488;
  localparam logic [15:0] TypePppIp  = 16'h2100;
  localparam logic [15:0] TypeIpv4   = 16'h0008;
  localparam logic [15:0] VlanSkip   = 16'd2;
  localparam logic [15:0] PppoeSkip  = 16'd6;

  localparam logic [7:0] ProtoUdp     = 8'h11;
  localparam logic [7:0] DnsPortHi    = 8'h00;
  localparam logic [7:0] DnsPortLo    = 8'h35;
  localparam logic [7:0] FlagsFirst   = 8'h81;
  localparam logic [7:0] FlagsSecond  = 8'h80;
  localparam logic [7:0] RrTypeHi     = 8'h00;
  localparam logic [7:0] RrTypeCname  = 8'h05;
  localparam logic [7:0] RrTypeA      = 8'h01;

  // Parser phases.
  typedef enum logic [3:0] {
    PH_HDR   = 4'd0,
    PH_TYPE  = 4'd1,
    PH_TAG   = 4'd2,
    PH_IP    = 4'd3,
    PH_UDP   = 4'd4,
    PH_DNS   = 4'd5,
    PH_QNAME = 4'd6,
    PH_QTAIL = 4'd7,
    PH_RTYPE = 4'd8,
    PH_RFIX  = 4'd9,
    PH_RLEN  = 4'd10,
    PH_RDATA = 4'd11,
    PH_RPTR  = 4'd12,
    PH_AFIX  = 4'd13,
    PH_ADDR  = 4'd14,
    PH_DONE  = 4'd15
  } phase_e;

  // Result codes.
  typedef enum logic [1:0] {
    ST_NO_MATCH  = 2'd0,
    ST_BAD_FLAGS = 2'd1,
    ST_BAD_TYPE  = 2'd2,
    ST_FOUND     = 2'd3
  } status_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_SERVER_ADDR = 2'd0,
    CFG_CLIENT_PORT = 2'd1,
    CFG_TRANS_ID    = 2'd2
  } cfg_idx_e;

  // Configuration values handed to the parser.
  typedef struct packed {
    logic [31:0] server_addr;
    logic [15:0] client_port;
    logic [15:0] trans_id;
  } cfg_t;

  // Per-frame result leaving the parser on the last byte.
  typedef struct packed {
    logic        valid;
    status_e     status;
    logic [31:0] addr;
  } result_t;

endpackage

/* rtl/drap_parser.sv */
module drap_parser import drap_pkg::*; #(
  parameter int unsigned MaxFrameBytes = MaxFrameBytesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] frame_byte_i,
  input  logic       frame_end_i,
  input  cfg_t       cfg_i,
  output result_t    result_o
);

  localparam int unsigned CntW = $clog2(MaxFrameBytes + 1);

  phase_e      phase_q, phase_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [4:0]  off_q, off_d;
  logic [15:0] skip_q, skip_d;
  logic [7:0]  held_q, held_d;
  status_e     verdict_q, verdict_d;
  logic        final_q, final_d;
  logic [31:0] capt_q, capt_d;

  logic [15:0] type_word;
  logic [15:0] skip_dec;
  logic [7:0]  srv_byte;

  assign type_word = {frame_byte_i, held_q};
  assign skip_dec  = skip_q - 16'd1;
  assign srv_byte  = cfg_i.server_addr[{off_q[1:0], 3'b000} +: 8];

  // Next-state logic for one frame byte, plus the result on the last byte.
  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    off_d     = off_q;
    skip_d    = skip_q;
    held_d    = held_q;
    verdict_d = verdict_q;
    final_d   = final_q;
    capt_d    = capt_q;
    result_o  = '0;

    if (accept_i) begin
      if (cnt_q >= CntW'(MaxFrameBytes)) begin
        // Oversize frame: close the verdict as not matching.
        verdict_d = ST_NO_MATCH;
        final_d   = 1'b1;
        phase_d   = PH_DONE;
      end else begin
        cnt_d = cnt_q + CntW'(1);
        if (!final_q) begin
          unique case (phase_q)
            PH_HDR: begin
              if (cnt_d >= CntW'(HdrBytes)) begin
                phase_d = PH_TYPE;
                off_d   = '0;
              end
            end
            PH_TYPE: begin
              if (off_q == 5'd0) begin
                held_d = frame_byte_i;
                off_d  = 5'd1;
              end else begin
                off_d = '0;
                if (type_word == TypeVlan) begin
                  skip_d  = VlanSkip;
                  phase_d = PH_TAG;
                end else if (type_word == TypePppoe) begin
                  skip_d  = PppoeSkip;
                  phase_d = PH_TAG;
                end else if (type_word == TypePppIp || type_word == TypeIpv4) begin
                  phase_d = PH_IP;
                end else begin
                  verdict_d = ST_NO_MATCH;
                  final_d   = 1'b1;
                  phase_d   = PH_DONE;
                end
              end
            end
            PH_TAG: begin
              skip_d = skip_dec;
              if (skip_dec == 16'd0) begin
                phase_d = PH_TYPE;
                off_d   = '0;
              end
            end
            PH_IP: begin
              if ((off_q == 5'd9 && frame_byte_i != ProtoUdp) ||
                  (off_q >= 5'd12 && off_q <= 5'd15 && frame_byte_i != srv_byte)) begin
                verdict_d = ST_NO_MATCH;
                final_d   = 1'b1;
                phase_d   = PH_DONE;
              end else if (off_q == 5'd19) begin
                phase_d = PH_UDP;
                off_d   = '0;
              end else begin
                off_d = off_q + 5'd1;
              end
            end
            PH_UDP: begin
              if ((off_q == 5'd0 && frame_byte_i != DnsPortHi) ||
                  (off_q == 5'd1 && frame_byte_i != DnsPortLo) ||
                  (off_q == 5'd2 && frame_byte_i != cfg_i.client_port[7:0]) ||
                  (off_q == 5'd3 && frame_byte_i != cfg_i.client_port[15:8])) begin
                verdict_d = ST_NO_MATCH;
                final_d   = 1'b1;
                phase_d   = PH_DONE;
              end else if (off_q == 5'd7) begin
                phase_d = PH_DNS;
                off_d   = '0;
              end else begin
                off_d = off_q + 5'd1;
              end
            end
            PH_DNS: begin
              if ((off_q == 5'd0 && frame_byte_i != cfg_i.trans_id[7:0]) ||
                  (off_q == 5'd1 && frame_byte_i != cfg_i.trans_id[15:8])) begin
                verdict_d = ST_NO_MATCH;
                final_d   = 1'b1;
                phase_d   = PH_DONE;
              end else begin
                if (off_q == 5'd2) begin
                  held_d = frame_byte_i;
                end
                if (off_q == 5'd3 &&
                    (held_q != FlagsFirst || frame_byte_i != FlagsSecond)) begin
                  verdict_d = ST_BAD_FLAGS;
                  final_d   = 1'b1;
                  phase_d   = PH_DONE;
                end else if (off_q == 5'd11) begin
                  phase_d = PH_QNAME;
                  off_d   = '0;
                end else begin
                  off_d = off_q + 5'd1;
                end
              end
            end
            PH_QNAME: begin
              if (frame_byte_i == 8'd0) begin
                phase_d = PH_QTAIL;
                off_d   = '0;
              end
            end
            PH_QTAIL: begin
              if (off_q == 5'd5) begin
                phase_d = PH_RTYPE;
                off_d   = '0;
              end else begin
                off_d = off_q + 5'd1;
              end
            end
            PH_RTYPE: begin
              if (off_q == 5'd0) begin
                held_d = frame_byte_i;
                off_d  = 5'd1;
              end else if (held_q == RrTypeHi && frame_byte_i == RrTypeCname) begin
                phase_d = PH_RFIX;
                off_d   = '0;
              end else if (held_q == RrTypeHi && frame_byte_i == RrTypeA) begin
                phase_d = PH_AFIX;
                off_d   = '0;
              end else begin
                verdict_d = ST_BAD_TYPE;
                final_d   = 1'b1;
                phase_d   = PH_DONE;
              end
            end
            PH_RFIX: begin
              if (off_q == 5'd5) begin
                phase_d = PH_RLEN;
                off_d   = '0;
              end else begin
                off_d = off_q + 5'd1;
              end
            end
            PH_RLEN: begin
              if (off_q == 5'd0) begin
                held_d = frame_byte_i;
                off_d  = 5'd1;
              end else begin
                skip_d  = {held_q, frame_byte_i};
                off_d   = '0;
                phase_d = ({held_q, frame_byte_i} != 16'd0) ? PH_RDATA : PH_RPTR;
              end
            end
            PH_RDATA: begin
              skip_d = skip_dec;
              if (skip_dec == 16'd0) begin
                phase_d = PH_RPTR;
                off_d   = '0;
              end
            end
            PH_RPTR: begin
              if (off_q == 5'd1) begin
                phase_d = PH_RTYPE;
                off_d   = '0;
              end else begin
                off_d = 5'd1;
              end
            end
            PH_AFIX: begin
              if (off_q == 5'd7) begin
                phase_d = PH_ADDR;
                off_d   = '0;
                capt_d  = '0;
              end else begin
                off_d = off_q + 5'd1;
              end
            end
            PH_ADDR: begin
              capt_d[{off_q[1:0], 3'b000} +: 8] = frame_byte_i;
              if (off_q >= 5'd3) begin
                verdict_d = ST_FOUND;
                final_d   = 1'b1;
                phase_d   = PH_DONE;
              end else begin
                off_d = off_q + 5'd1;
              end
            end
            PH_DONE: begin
            end
            default: begin
            end
          endcase
        end
      end

      // The last byte reports the verdict and clears the frame state.
      if (frame_end_i) begin
        result_o.valid  = 1'b1;
        result_o.status = (final_d && cnt_d >= CntW'(MinFrameBytes)) ? verdict_d
                                                                     : ST_NO_MATCH;
        result_o.addr   = (result_o.status == ST_FOUND) ? capt_d : '0;
        phase_d   = PH_HDR;
        cnt_d     = '0;
        off_d     = '0;
        skip_d    = '0;
        held_d    = '0;
        verdict_d = ST_NO_MATCH;
        final_d   = 1'b0;
        capt_d    = '0;
      end
    end
  end

  // Frame state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HDR;
      cnt_q     <= '0;
      off_q     <= '0;
      skip_q    <= '0;
      held_q    <= '0;
      verdict_q <= ST_NO_MATCH;
      final_q   <= 1'b0;
      capt_q    <= '0;
    end else begin
      phase_q   <= phase_d;
      cnt_q     <= cnt_d;
      off_q     <= off_d;
      skip_q    <= skip_d;
      held_q    <= held_d;
      verdict_q <= verdict_d;
      final_q   <= final_d;
      capt_q    <= capt_d;
    end
  end

endmodule

/* rtl/dns_response_address_parser.sv */
// Parses an Ethernet frame delivered one byte per transaction and reports,
// on the byte marked as the frame end, whether it is the expected DNS A-record
// response and, if so, the resolved IPv4 address. The block takes one byte
// every clock cycle: each byte advances the parser state, and the per-frame
// result appears in the output register in the cycle after the last byte is
// accepted. The output register frees in the same cycle its result is taken,
// so input only stalls while a result waits downstream. Configuration
// registers (server address, client port, transaction id, all in wire byte
// order with the first byte in bits 7..0) must be written by the user only
// while no frame is in progress; the block itself does not enforce this.
module dns_response_address_parser import drap_pkg::*; #(
  parameter int unsigned MaxFrameBytes = MaxFrameBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  frame_byte_i,
  input  logic        frame_end_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [31:0] resolved_address_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

`include "dns_response_address_parser_assert.svh"

  cfg_t        cfg_q;
  result_t     result;
  logic        in_accept;
  logic        out_valid_q;
  logic [1:0]  status_q;
  logic [31:0] addr_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_accept  = in_valid_i && in_ready_o;

  // Configuration register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_SERVER_ADDR: cfg_q.server_addr <= cfg_data_i;
        CFG_CLIENT_PORT: cfg_q.client_port <= cfg_data_i[15:0];
        CFG_TRANS_ID:    cfg_q.trans_id    <= cfg_data_i[15:0];
        default: begin
        end
      endcase
    end
  end

  drap_parser #(
    .MaxFrameBytes(MaxFrameBytes)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .frame_byte_i(frame_byte_i),
    .frame_end_i (frame_end_i),
    .cfg_i       (cfg_q),
    .result_o    (result)
  );

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (result.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (result.valid) begin
      status_q <= result.status;
      addr_q   <= result.addr;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign resolved_address_o = addr_q;

  // A frame end always produces a result in the next cycle.
  `DRAP_ASSERT(a_end_gives_result, clk_i, rst_ni,
    (in_accept && frame_end_i) |=> out_valid_o, "frame end without result")

  // A non-final byte never creates a result on its own.
  `DRAP_ASSERT(a_no_spurious_result, clk_i, rst_ni,
    (in_accept && !frame_end_i && out_ready_i) |=> !out_valid_o, "spurious result")

  // The address is only reported together with a found status.
  `DRAP_ASSERT(a_addr_only_when_found, clk_i, rst_ni,
    (out_valid_o && status_o != ST_FOUND) |-> (resolved_address_o == 32'd0),
    "address reported without a found status")

endmodule

/* dv/testbench.sv */
module testbench import drap_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // Header fields that a broken reply can carry a wrong value in.
  typedef enum int unsigned {
    BRK_PROTO,
    BRK_SRC_IP,
    BRK_SRC_PORT,
    BRK_DST_PORT,
    BRK_TID,
    BRK_FLAGS
  } header_fault_e;

  // Content of one DNS reply frame. Multi-byte values hold the first wire byte
  // in bits 7..0, as the block's registers do.
  typedef struct {
    int unsigned tags;
    logic [7:0]  pppoe_mask;
    logic        ppp_ip;
    logic [7:0]  proto;
    logic [31:0] src_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [15:0] tid;
    logic [15:0] flags;
    int unsigned qname_len;
    int unsigned cnames;
    int unsigned rdlen_min;
    int unsigned rdlen_max;
    logic [15:0] rtype;
    logic [31:0] address;
    int unsigned trailer;
  } reply_t;

  // One status result that the block owes.
  typedef struct packed {
    status_e     status;
    logic [31:0] addr;
  } reply_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  frame_byte_i;
  logic        frame_end_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  status_o;
  logic [31:0] resolved_address_o;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  // Mirror of the configuration registers.
  logic [31:0] cfg_server;
  logic [15:0] cfg_port;
  logic [15:0] cfg_tid;

  // Parser state of the predictor.
  phase_e      ps_phase;
  int unsigned ps_count;
  int unsigned ps_off;
  logic [15:0] ps_skip;
  logic [7:0]  ps_held;
  status_e     ps_verdict;
  logic        ps_final;
  logic [31:0] ps_addr;

  reply_result_t pending_replies[$];
  logic [7:0]    frame_bytes[$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned error_count;
  int unsigned bytes_accepted;
  int unsigned status_tally[4];

  dns_response_address_parser u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .frame_byte_i       (frame_byte_i),
    .frame_end_i        (frame_end_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .status_o           (status_o),
    .resolved_address_o (resolved_address_o),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Hard limit on the run time.
  initial begin
    #5ms;
    $display("** dns_response_address_parser: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void clear_parse();
    ps_phase   = PH_HDR;
    ps_count   = 0;
    ps_off     = 0;
    ps_skip    = '0;
    ps_held    = '0;
    ps_verdict = ST_NO_MATCH;
    ps_final   = 1'b0;
    ps_addr    = '0;
  endfunction

  function automatic void conclude(status_e v);
    ps_verdict = v;
    ps_final   = 1'b1;
    ps_phase   = PH_DONE;
  endfunction

  function automatic void enter_phase(phase_e p);
    ps_phase = p;
    ps_off   = 0;
  endfunction

  // Advances the parser by one byte of a frame that has not reached a verdict.
  function automatic void parse_byte(logic [7:0] b);
    logic [15:0] word;
    logic [31:0] srv;
    word = {b, ps_held};
    srv  = cfg_server >> (8 * (ps_off & 3));
    case (ps_phase)
      PH_HDR: begin
        if (ps_count >= HdrBytes) enter_phase(PH_TYPE);
      end
      PH_TYPE: begin
        if (ps_off == 0) begin
          ps_held = b;
          ps_off  = 1;
        end else begin
          ps_off = 0;
          if (word == TypeVlan) begin
            ps_skip  = VlanSkip;
            ps_phase = PH_TAG;
          end else if (word == TypePppoe) begin
            ps_skip  = PppoeSkip;
            ps_phase = PH_TAG;
          end else if (word == TypePppIp || word == TypeIpv4) begin
            enter_phase(PH_IP);
          end else begin
            conclude(ST_NO_MATCH);
          end
        end
      end
      PH_TAG: begin
        ps_skip = ps_skip - 16'd1;
        if (ps_skip == 0) enter_phase(PH_TYPE);
      end
      PH_IP: begin
        if (ps_off == 9 && b != ProtoUdp) conclude(ST_NO_MATCH);
        else if (ps_off >= 12 && ps_off <= 15 && b != srv[7:0]) conclude(ST_NO_MATCH);
        else if (ps_off == 19) enter_phase(PH_UDP);
        else ps_off++;
      end
      PH_UDP: begin
        if ((ps_off == 0 && b != DnsPortHi) || (ps_off == 1 && b != DnsPortLo) ||
            (ps_off == 2 && b != cfg_port[7:0]) || (ps_off == 3 && b != cfg_port[15:8])) begin
          conclude(ST_NO_MATCH);
        end else if (ps_off == 7) begin
          enter_phase(PH_DNS);
        end else begin
          ps_off++;
        end
      end
      PH_DNS: begin
        if ((ps_off == 0 && b != cfg_tid[7:0]) || (ps_off == 1 && b != cfg_tid[15:8])) begin
          conclude(ST_NO_MATCH);
        end else begin
          if (ps_off == 2) ps_held = b;
          if (ps_off == 3 && (ps_held != FlagsFirst || b != FlagsSecond)) conclude(ST_BAD_FLAGS);
          else if (ps_off == 11) enter_phase(PH_QNAME);
          else ps_off++;
        end
      end
      PH_QNAME: begin
        if (b == 8'h00) enter_phase(PH_QTAIL);
      end
      PH_QTAIL: begin
        if (ps_off == 5) enter_phase(PH_RTYPE);
        else ps_off++;
      end
      PH_RTYPE: begin
        if (ps_off == 0) begin
          ps_held = b;
          ps_off  = 1;
        end else if (ps_held == RrTypeHi && b == RrTypeCname) begin
          enter_phase(PH_RFIX);
        end else if (ps_held == RrTypeHi && b == RrTypeA) begin
          enter_phase(PH_AFIX);
        end else begin
          conclude(ST_BAD_TYPE);
        end
      end
      PH_RFIX: begin
        if (ps_off == 5) enter_phase(PH_RLEN);
        else ps_off++;
      end
      PH_RLEN: begin
        if (ps_off == 0) begin
          ps_held = b;
          ps_off  = 1;
        end else begin
          ps_skip = {ps_held, b};
          enter_phase(ps_skip != 0 ? PH_RDATA : PH_RPTR);
        end
      end
      PH_RDATA: begin
        ps_skip = ps_skip - 16'd1;
        if (ps_skip == 0) enter_phase(PH_RPTR);
      end
      PH_RPTR: begin
        if (ps_off == 1) enter_phase(PH_RTYPE);
        else ps_off = 1;
      end
      PH_AFIX: begin
        if (ps_off == 7) begin
          enter_phase(PH_ADDR);
          ps_addr = '0;
        end else begin
          ps_off++;
        end
      end
      PH_ADDR: begin
        ps_addr |= 32'(b) << (8 * (ps_off & 3));
        if (ps_off >= 3) conclude(ST_FOUND);
        else ps_off++;
      end
      default: ;
    endcase
  endfunction

  // Takes one accepted byte; on the frame end it queues the result that is owed.
  function automatic void track_frame_byte(logic [7:0] b, logic last);
    reply_result_t want;
    if (ps_count >= MaxFrameBytesDef) begin
      conclude(ST_NO_MATCH);
    end else begin
      ps_count++;
      if (!ps_final) parse_byte(b);
    end
    if (last) begin
      want.status = ST_NO_MATCH;
      want.addr   = '0;
      if (ps_final && ps_count >= MinFrameBytes) want.status = ps_verdict;
      if (want.status == ST_FOUND) want.addr = ps_addr;
      pending_replies.push_back(want);
      clear_parse();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  function automatic void note_error(string msg);
    error_count++;
    if (error_count <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
  endfunction

  function automatic void check_reply(logic [1:0] got_status, logic [31:0] got_addr);
    reply_result_t want;
    if (pending_replies.size() == 0) begin
      note_error($sformatf("result with no frame pending: status %0d address %h",
                           got_status, got_addr));
      return;
    end
    want = pending_replies.pop_front();
    status_tally[want.status]++;
    if (got_status != want.status)
      note_error($sformatf("status expected %0d, got %0d", want.status, got_status));
    if (got_addr != want.addr)
      note_error($sformatf("address expected %h, got %h", want.addr, got_addr));
  endfunction

  // Both channels are sampled at the rising edge: the result transaction is
  // checked first, then the byte transaction is handed to the predictor.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) check_reply(status_o, resolved_address_o);
      if (in_valid_i && in_ready_o) begin
        bytes_accepted++;
        track_frame_byte(frame_byte_i, frame_end_i);
      end
    end
  end

  // The receiver stalls at random.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // Frame building
  // ---------------------------------------------------------------------------

  function automatic void put_random(int unsigned n);
    repeat (n) frame_bytes.push_back(8'($urandom));
  endfunction

  function automatic void put_word(logic [15:0] w);
    frame_bytes.push_back(w[7:0]);
    frame_bytes.push_back(w[15:8]);
  endfunction

  function automatic void trim_frame(int unsigned n);
    while (frame_bytes.size() > n) void'(frame_bytes.pop_back());
  endfunction

  // A reply that matches the current configuration and carries one A record.
  function automatic reply_t good_reply();
    reply_t r;
    r.tags       = 0;
    r.pppoe_mask = 8'($urandom);
    r.ppp_ip     = 1'b0;
    r.proto      = ProtoUdp;
    r.src_ip     = cfg_server;
    r.src_port   = {DnsPortLo, DnsPortHi};
    r.dst_port   = cfg_port;
    r.tid        = cfg_tid;
    r.flags      = {FlagsSecond, FlagsFirst};
    r.qname_len  = $urandom_range(24, 1);
    r.cnames     = 0;
    r.rdlen_min  = 0;
    r.rdlen_max  = 12;
    r.rtype      = {RrTypeA, RrTypeHi};
    r.address    = $urandom;
    r.trailer    = $urandom_range(6, 0);
    return r;
  endfunction

  function automatic reply_t broken(reply_t r, header_fault_e fault);
    logic [7:0] flip;
    flip = 8'($urandom_range(255, 1));
    case (fault)
      BRK_PROTO:    r.proto    ^= flip;
      BRK_SRC_IP:   r.src_ip   ^= 32'(flip) << (8 * $urandom_range(3));
      BRK_SRC_PORT: r.src_port ^= 16'(flip) << (8 * $urandom_range(1));
      BRK_DST_PORT: r.dst_port ^= 16'(flip) << (8 * $urandom_range(1));
      BRK_TID:      r.tid      ^= 16'(flip) << (8 * $urandom_range(1));
      default:      r.flags    ^= 16'(flip) << (8 * $urandom_range(1));
    endcase
    return r;
  endfunction

  function automatic void build_reply(reply_t r);
    logic [15:0] len;
    frame_bytes.delete();
    put_random(12);
    for (int i = 0; i < r.tags; i++) begin
      if (r.pppoe_mask[i % 8]) begin
        put_word(TypePppoe);
        put_random(6);
      end else begin
        put_word(TypeVlan);
        put_random(2);
      end
    end
    put_word(r.ppp_ip ? TypePppIp : TypeIpv4);
    // IPv4 header; the length nibble is random since the parser ignores it.
    frame_bytes.push_back({4'h4, 4'($urandom)});
    put_random(8);
    frame_bytes.push_back(r.proto);
    put_random(2);
    put_word(r.src_ip[15:0]);
    put_word(r.src_ip[31:16]);
    put_random(4);
    put_word(r.src_port);
    put_word(r.dst_port);
    put_random(4);
    put_word(r.tid);
    put_word(r.flags);
    put_random(8);
    repeat (r.qname_len) frame_bytes.push_back(8'($urandom_range(255, 1)));
    frame_bytes.push_back(8'h00);
    put_random(6);
    // Alias records, each followed by the name pointer of the next record.
    repeat (r.cnames) begin
      put_word({RrTypeCname, RrTypeHi});
      put_random(6);
      len = 16'($urandom_range(r.rdlen_max, r.rdlen_min));
      frame_bytes.push_back(len[15:8]);
      frame_bytes.push_back(len[7:0]);
      put_random(len);
      put_random(2);
    end
    put_word(r.rtype);
    put_random(8);
    put_word(r.address[15:0]);
    put_word(r.address[31:16]);
    put_random(r.trailer);
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    frame_byte_i <= b;
    frame_end_i  <= last;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic send_frame();
    foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  // Holds the sender off until every owed result has arrived.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_replies.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic load_config(input logic [31:0] server, input logic [15:0] port,
                             input logic [15:0] tid);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_SERVER_ADDR;
    cfg_data_i  <= server;
    @(negedge clk_i);
    cfg_index_i <= CFG_CLIENT_PORT;
    cfg_data_i  <= {16'h0000, port};
    @(negedge clk_i);
    cfg_index_i <= CFG_TRANS_ID;
    cfg_data_i  <= {16'h0000, tid};
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    cfg_server = server;
    cfg_port   = port;
    cfg_tid    = tid;
  endtask

  task automatic send_reply(input reply_t r);
    build_reply(r);
    send_frame();
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // The registers come out of reset as zero, so a reply from 0.0.0.0 matches.
  task automatic test_reset_defaults();
    send_reply(good_reply());
  endtask

  task automatic test_encapsulation();
    reply_t r;
    wait_idle();
    load_config($urandom, 16'($urandom), 16'($urandom));
    r = good_reply();
    r.tags = 1;
    r.pppoe_mask = 8'h00;
    send_reply(r);
    r.pppoe_mask = 8'h01;
    r.ppp_ip = 1'b1;
    send_reply(r);
    r.tags = 3;
    r.pppoe_mask = 8'h02;
    r.ppp_ip = 1'b0;
    send_reply(r);
    r.tags = 0;
    r.ppp_ip = 1'b1;
    send_reply(r);
    // An IPv6 type word is not followed.
    build_reply(good_reply());
    frame_bytes[12] = 8'h86;
    frame_bytes[13] = 8'hdd;
    send_frame();
  endtask

  task automatic test_header_checks();
    wait_idle();
    load_config($urandom, 16'($urandom), 16'($urandom));
    for (int k = BRK_PROTO; k <= BRK_FLAGS; k++)
      send_reply(broken(good_reply(), header_fault_e'(k)));
  endtask

  task automatic test_answer_records();
    reply_t r;
    wait_idle();
    load_config($urandom, 16'($urandom), 16'($urandom));
    r = good_reply();
    r.cnames = 3;
    send_reply(r);
    r.cnames = 1;
    r.rdlen_max = 0;
    send_reply(r);
    r.rdlen_min = 256;
    r.rdlen_max = 256;
    send_reply(r);
    // An IPv6 address record, then a type with a nonzero first byte.
    r = good_reply();
    r.rtype = 16'h1c00;
    send_reply(r);
    r.cnames = 1;
    r.rtype = 16'h0105;
    send_reply(r);
  endtask

  task automatic test_frame_lengths();
    reply_t r;
    wait_idle();
    load_config($urandom, 16'($urandom), 16'($urandom));
    frame_bytes.delete();
    put_random(1);
    send_frame();
    build_reply(good_reply());
    trim_frame(MinFrameBytes - 1);
    send_frame();
    // Frame ends on the first byte of the transaction id.
    build_reply(good_reply());
    trim_frame(43);
    send_frame();
    // Frame ends inside the captured address.
    r = good_reply();
    r.trailer = 0;
    build_reply(r);
    trim_frame(frame_bytes.size() - 2);
    send_frame();
  endtask

  task automatic test_config_extremes();
    reply_t r;
    wait_idle();
    load_config(32'hffff_ffff, 16'hffff, 16'hffff);
    r = good_reply();
    r.trailer = 40;
    send_reply(r);
    r = good_reply();
    r.tags = 2;
    r.cnames = 2;
    send_reply(r);
    send_reply(broken(good_reply(), BRK_TID));
    wait_idle();
    load_config('0, '0, '0);
    send_reply(good_reply());
  endtask

  // Mostly well-formed replies with random content, plus broken headers,
  // truncated frames and noise.
  task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct);
    reply_t r;
    int unsigned pick;
    int unsigned sent_bytes;
    wait_idle();
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    load_config($urandom, 16'($urandom), 16'($urandom));
    sent_bytes = 0;
    while (sent_bytes < 200) begin
      pick = $urandom_range(99);
      r = good_reply();
      r.tags   = $urandom_range(2);
      r.ppp_ip = 1'($urandom);
      r.cnames = $urandom_range(3);
      if ($urandom_range(19) == 0) r.rdlen_max = 300;
      if ($urandom_range(9) == 0) r.rtype = 16'($urandom);
      if (pick >= 60 && pick < 80) r = broken(r, header_fault_e'($urandom_range(BRK_FLAGS)));
      build_reply(r);
      if (pick >= 80 && pick < 90) trim_frame($urandom_range(frame_bytes.size(), 1));
      if (pick >= 90) begin
        frame_bytes.delete();
        put_random($urandom_range(64, 1));
      end
      if ($urandom_range(9) == 0) wait_idle();
      sent_bytes += frame_bytes.size();
      send_frame();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    frame_byte_i = '0;
    frame_end_i  = 1'b0;
    out_ready_i  = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_index_i  = CFG_SERVER_ADDR;
    cfg_data_i   = '0;
    cfg_server   = '0;
    cfg_port     = '0;
    cfg_tid      = '0;
    send_idle_pct  = 33;
    recv_idle_pct  = 53;
    error_count    = 0;
    bytes_accepted = 0;
    foreach (status_tally[i]) status_tally[i] = 0;
    clear_parse();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_encapsulation();
    test_header_checks();
    test_answer_records();
    test_frame_lengths();
    test_config_extremes();
    test_random_traffic(33, 53);
    test_random_traffic(53, 33);
    test_random_traffic(0, 0);

    wait_idle();
    repeat (8) @(negedge clk_i);
    if (pending_replies.size() != 0) note_error("results still owed at the end of the run");
    $display("Frames checked: %0d over %0d bytes; %0d addresses resolved, %0d bad flags,",
             status_tally[0] + status_tally[1] + status_tally[2] + status_tally[3],
             bytes_accepted, status_tally[ST_FOUND], status_tally[ST_BAD_FLAGS]);
    $display("%0d bad record types, %0d not matching; %0d mismatches counted.",
             status_tally[ST_BAD_TYPE], status_tally[ST_NO_MATCH], error_count);
    if (error_count == 0) begin
      $display("** dns_response_address_parser: PASSED **");
    end else begin
      $display("** dns_response_address_parser: FAILED **");
    end
    $finish;
  end

endmodule
